[hdl/stds_pkg.sv]
`timescale 1ns / 1ps

package stds_pkg;

    localparam int NUM_DIGITS   = 4;
    localparam int SLOT_W       = $clog2(NUM_DIGITS);
    localparam int BLINK_ROUNDS = 16;
    localparam int ROUND_W      = $clog2(BLINK_ROUNDS);

    localparam int VALUE_W  = 14;
    localparam int SAMPLE_W = 10;
    localparam int OFFSET_W = 10;
    localparam int SCALE_W  = 12;
    localparam int LEVEL_W  = 11;
    localparam int PROD_W   = VALUE_W + SCALE_W;
    localparam int FRAC_W   = 12;
    localparam int BCD_W    = 16;
    localparam int CFG_W    = 12;
    localparam int CFG_IDX_W = 2;
    localparam int ENABLE_W = 4;

    typedef enum logic [1:0] {
        CMD_SAMPLE  = 2'd0,
        CMD_BUTTONS = 2'd1,
        CMD_TICK    = 2'd2,
        CMD_SLOT    = 2'd3
    } cmd_t;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_OFFSET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_SCALE       = 2'd1;

    localparam int BTN_ARM       = 0;
    localparam int BTN_ONES      = 1;
    localparam int BTN_TENS      = 2;
    localparam int BTN_HUNDREDS  = 3;
    localparam int BTN_THOUSANDS = 4;

    localparam logic [OFFSET_W-1:0] OFFSET_RESET  = 10'd100;
    localparam logic [SCALE_W-1:0]  SCALE_RESET   = 12'd3750;
    localparam logic [LEVEL_W-1:0]  TRIGGER_RESET = 11'd140;
    localparam logic [VALUE_W-1:0]  TICK_MAX      = 14'd16383;
    localparam logic [PROD_W-1:0]   PROD_RESET    = 26'd3750;

    // floor(x/10) and floor(x/100) are exact for any 14-bit x with these
    localparam logic [15:0] DIV10_MUL  = 16'd52429;
    localparam logic [12:0] DIV100_MUL = 13'd5243;
    localparam int          DIV_SHIFT  = 19;

    typedef struct packed {
        logic                strobe_fire;
        logic                adc_start;
        logic                segments_load;
        logic [7:0]          segments;
        logic [ENABLE_W-1:0] digit_enable;
        logic                is_armed;
        logic                is_firing;
    } result_t;

    function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
        logic [7:0] pat;
        unique case (digit)
            4'd0:    pat = 8'hFD;
            4'd1:    pat = 8'h28;
            4'd2:    pat = 8'hE7;
            4'd3:    pat = 8'h6F;
            4'd4:    pat = 8'h3B;
            4'd5:    pat = 8'h5F;
            4'd6:    pat = 8'hDF;
            4'd7:    pat = 8'h2C;
            4'd8:    pat = 8'hFF;
            4'd9:    pat = 8'h7F;
            default: pat = 8'h00;
        endcase
        return pat;
    endfunction

    function automatic logic [VALUE_W-1:0] place_value(input logic [1:0] idx);
        logic [VALUE_W-1:0] v;
        unique case (idx)
            2'd0:    v = 14'd1;
            2'd1:    v = 14'd10;
            2'd2:    v = 14'd100;
            default: v = 14'd1000;
        endcase
        return v;
    endfunction

    function automatic logic [VALUE_W-1:0] nine_place(input logic [1:0] idx);
        logic [VALUE_W-1:0] v;
        unique case (idx)
            2'd0:    v = 14'd9;
            2'd1:    v = 14'd90;
            2'd2:    v = 14'd900;
            default: v = 14'd9000;
        endcase
        return v;
    endfunction

endpackage

[hdl/sound_triggered_delay_strobe.sv]
`timescale 1ns / 1ps

// Sound-triggered delay strobe controller. Each input word is one event (converter sample,
// button snapshot, timer tick or display slot) and yields exactly one result word. A word
// can be taken on every clock while in_stall is low: all event work is a short path from
// the accepted word and the state registers into the output or skid register. The
// tick-times-scale product for the next tick is registered from the next state, so a
// tick never waits on the multiplier. Results leave through an output register
// backed by a skid register; in_stall rises only while both hold a word the downstream
// side has not taken. Configuration writes take effect at the write edge.
module sound_triggered_delay_strobe (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [stds_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [stds_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     cmd,
    input  logic [stds_pkg::SAMPLE_W-1:0]  sample,
    input  logic [4:0]                     buttons,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           strobe_fire,
    output logic                           adc_start,
    output logic                           segments_load,
    output logic [7:0]                     segments,
    output logic [stds_pkg::ENABLE_W-1:0]  digit_enable,
    output logic                           is_armed,
    output logic                           is_firing
);

    localparam int VW = stds_pkg::VALUE_W;

    // configuration
    logic [stds_pkg::OFFSET_W-1:0] offset_reg;
    logic [stds_pkg::SCALE_W-1:0]  scale_reg, scale_next;

    // event state
    logic [stds_pkg::BCD_W-1:0]    delay_bcd_reg, delay_bcd_next;
    logic [VW-1:0]                 delay_reg, delay_next;
    logic [VW-1:0]                 shown_reg, shown_next;
    logic [10:0]                   shown_d10_reg, shown_d10_next;
    logic [7:0]                    shown_d100_reg, shown_d100_next;
    logic [VW-1:0]                 tick_reg, tick_next;
    logic [stds_pkg::PROD_W-1:0]   prod_reg, prod_next;
    logic [stds_pkg::SAMPLE_W-1:0] last_sample_reg, last_sample_next;
    logic [stds_pkg::LEVEL_W-1:0]  trigger_reg, trigger_next;
    logic                          armed_reg, armed_next;
    logic                          firing_reg, firing_next;
    logic                          blink_reg, blink_next;
    logic [stds_pkg::SLOT_W-1:0]   slot_reg, slot_next;
    logic [stds_pkg::ROUND_W-1:0]  rounds_reg, rounds_next;
    logic [10:0]                   scan_d10_reg, scan_d10_next;
    logic [7:0]                    scan_d100_reg, scan_d100_next;

    // output register and skid
    stds_pkg::result_t             out_reg, out_next;
    stds_pkg::result_t             skid_reg, skid_next;
    logic                          out_valid_reg, out_valid_next;
    logic                          skid_valid_reg, skid_valid_next;
    stds_pkg::result_t             res;

    logic                          push, pop;
    stds_pkg::cmd_t                ev;

    // helpers
    logic                          bump_en;
    logic [1:0]                    bump_idx;
    logic [3:0]                    bump_digit;
    logic [VW-1:0]                 prod_q;
    logic                          expired;
    logic [VW-1:0]                 remaining;
    logic [29:0]                   rem_m10;
    logic [26:0]                   rem_m100;
    logic [VW-1:0]                 tick_inc;
    logic [VW-1:0]                 tick_ahead;
    logic                          wrap;
    logic [stds_pkg::SLOT_W-1:0]   slot_adv;
    logic [23:0]                   a_m100;
    logic [10:0]                   digit_wide;

    function automatic logic [10:0] bcd_div10(input logic [stds_pkg::BCD_W-1:0] bcd);
        return 11'(11'(bcd[15:12]) * 11'd100 + 11'(bcd[11:8]) * 11'd10 + 11'(bcd[7:4]));
    endfunction

    function automatic logic [7:0] bcd_div100(input logic [stds_pkg::BCD_W-1:0] bcd);
        return 8'(8'(bcd[15:12]) * 8'd10 + 8'(bcd[11:8]));
    endfunction

    assign push     = in_valid && !in_stall;
    assign pop      = out_valid_reg && !out_stall;
    assign in_stall = skid_valid_reg;
    assign ev       = stds_pkg::cmd_t'(cmd);

    assign prod_q    = prod_reg[stds_pkg::PROD_W-1:stds_pkg::FRAC_W];
    assign expired   = delay_reg <= prod_q;
    assign remaining = delay_reg - prod_q;
    assign rem_m10   = 30'(remaining) * 30'(stds_pkg::DIV10_MUL);
    assign rem_m100  = 27'(remaining) * 27'(stds_pkg::DIV100_MUL);
    assign a_m100    = 24'(scan_d10_reg) * 24'(stds_pkg::DIV100_MUL);
    assign tick_inc  = (tick_reg == stds_pkg::TICK_MAX) ? tick_reg : tick_reg + 14'd1;

    assign slot_adv = (slot_reg == stds_pkg::SLOT_W'(stds_pkg::NUM_DIGITS - 1))
                    ? '0 : slot_reg + stds_pkg::SLOT_W'(1);
    assign wrap     = (slot_adv == '0);

    // highest pressed digit button wins
    always_comb
    begin
        bump_en  = 1'b1;
        bump_idx = 2'd0;
        priority if (!buttons[stds_pkg::BTN_THOUSANDS])
            bump_idx = 2'd3;
        else if (!buttons[stds_pkg::BTN_HUNDREDS])
            bump_idx = 2'd2;
        else if (!buttons[stds_pkg::BTN_TENS])
            bump_idx = 2'd1;
        else if (!buttons[stds_pkg::BTN_ONES])
            bump_idx = 2'd0;
        else
            bump_en = 1'b0;
    end

    assign bump_digit = delay_bcd_reg[bump_idx*4 +: 4];

    always_comb
    begin
        scale_next       = scale_reg;
        delay_bcd_next   = delay_bcd_reg;
        delay_next       = delay_reg;
        shown_next       = shown_reg;
        shown_d10_next   = shown_d10_reg;
        shown_d100_next  = shown_d100_reg;
        tick_next        = tick_reg;
        last_sample_next = last_sample_reg;
        trigger_next     = trigger_reg;
        armed_next       = armed_reg;
        firing_next      = firing_reg;
        blink_next       = blink_reg;
        slot_next        = slot_reg;
        rounds_next      = rounds_reg;
        scan_d10_next    = scan_d10_reg;
        scan_d100_next   = scan_d100_reg;
        digit_wide       = '0;
        res              = '0;

        if (cfg_write && cfg_index == stds_pkg::CFG_TICK_SCALE)
            scale_next = cfg_data[stds_pkg::SCALE_W-1:0];

        if (push)
        begin
            unique case (ev)
                stds_pkg::CMD_SAMPLE:
                begin
                    if (armed_reg && 11'(sample) > trigger_reg)
                    begin
                        armed_next  = 1'b0;
                        firing_next = 1'b1;
                    end
                    last_sample_next = sample;
                end
                stds_pkg::CMD_BUTTONS:
                begin
                    if (bump_en)
                    begin
                        if (bump_digit == 4'd9)
                        begin
                            delay_bcd_next[bump_idx*4 +: 4] = 4'd0;
                            delay_next = delay_reg - stds_pkg::nine_place(bump_idx);
                        end
                        else
                        begin
                            delay_bcd_next[bump_idx*4 +: 4] = bump_digit + 4'd1;
                            delay_next = delay_reg + stds_pkg::place_value(bump_idx);
                        end
                    end
                    if (!buttons[stds_pkg::BTN_ARM])
                    begin
                        trigger_next = 11'(last_sample_reg) + 11'(offset_reg);
                        armed_next   = !armed_reg;
                    end
                    shown_next      = delay_next;
                    shown_d10_next  = bcd_div10(delay_bcd_next);
                    shown_d100_next = bcd_div100(delay_bcd_next);
                end
                stds_pkg::CMD_TICK:
                begin
                    if (firing_reg)
                    begin
                        if (expired)
                        begin
                            res.strobe_fire = 1'b1;
                            firing_next     = 1'b0;
                            tick_next       = '0;
                            shown_next      = delay_reg;
                            shown_d10_next  = bcd_div10(delay_bcd_reg);
                            shown_d100_next = bcd_div100(delay_bcd_reg);
                        end
                        else
                        begin
                            tick_next       = tick_inc;
                            shown_next      = remaining;
                            shown_d10_next  = rem_m10[29:stds_pkg::DIV_SHIFT];
                            shown_d100_next = rem_m100[26:stds_pkg::DIV_SHIFT];
                        end
                    end
                    else
                        res.adc_start = 1'b1;
                end
                stds_pkg::CMD_SLOT:
                begin
                    res.segments_load = 1'b1;
                    if (blink_reg)
                        res.digit_enable = stds_pkg::ENABLE_W'(1) << slot_adv;
                    slot_next = slot_adv;
                    if (wrap)
                    begin
                        // reload the scan from the shown value
                        digit_wide     = 11'(shown_reg) - 11'({shown_d10_reg, 3'b000})
                                       - 11'({shown_d10_reg, 1'b0});
                        scan_d10_next  = shown_d10_reg;
                        scan_d100_next = shown_d100_reg;
                        rounds_next    = (rounds_reg ==
                                          stds_pkg::ROUND_W'(stds_pkg::BLINK_ROUNDS - 1))
                                       ? '0 : rounds_reg + stds_pkg::ROUND_W'(1);
                        if (armed_reg)
                        begin
                            if (rounds_next == '0)
                                blink_next = !blink_reg;
                        end
                        else
                            blink_next = 1'b1;
                    end
                    else
                    begin
                        // shift the scan down one decimal place
                        digit_wide     = scan_d10_reg - 11'({scan_d100_reg, 3'b000})
                                       - 11'({scan_d100_reg, 1'b0});
                        scan_d10_next  = 11'(scan_d100_reg);
                        scan_d100_next = 8'(a_m100[23:stds_pkg::DIV_SHIFT]);
                    end
                    res.segments = stds_pkg::seg_pattern(digit_wide[3:0]);
                end
                default:
                begin
                end
            endcase
            res.is_armed  = armed_next;
            res.is_firing = firing_next;
        end
    end

    // product for the next tick, from next state
    assign tick_ahead = (tick_next == stds_pkg::TICK_MAX) ? tick_next : tick_next + 14'd1;
    assign prod_next  = stds_pkg::PROD_W'(tick_ahead) * stds_pkg::PROD_W'(scale_next);

    always_comb
    begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = push;
                skid_next       = res;
            end
            else
            begin
                out_next       = res;
                out_valid_next = push;
            end
        end
        else if (push)
        begin
            // hold the new word until the output drains
            skid_next       = res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg      <= stds_pkg::OFFSET_RESET;
            scale_reg       <= stds_pkg::SCALE_RESET;
            delay_bcd_reg   <= '0;
            delay_reg       <= '0;
            shown_reg       <= '0;
            shown_d10_reg   <= '0;
            shown_d100_reg  <= '0;
            tick_reg        <= '0;
            prod_reg        <= stds_pkg::PROD_RESET;
            last_sample_reg <= '0;
            trigger_reg     <= stds_pkg::TRIGGER_RESET;
            armed_reg       <= 1'b0;
            firing_reg      <= 1'b0;
            blink_reg       <= 1'b0;
            slot_reg        <= '0;
            rounds_reg      <= '0;
            scan_d10_reg    <= '0;
            scan_d100_reg   <= '0;
            out_valid_reg   <= 1'b0;
            skid_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write && cfg_index == stds_pkg::CFG_THRESHOLD_OFFSET)
                offset_reg <= cfg_data[stds_pkg::OFFSET_W-1:0];
            scale_reg       <= scale_next;
            delay_bcd_reg   <= delay_bcd_next;
            delay_reg       <= delay_next;
            shown_reg       <= shown_next;
            shown_d10_reg   <= shown_d10_next;
            shown_d100_reg  <= shown_d100_next;
            tick_reg        <= tick_next;
            prod_reg        <= prod_next;
            last_sample_reg <= last_sample_next;
            trigger_reg     <= trigger_next;
            armed_reg       <= armed_next;
            firing_reg      <= firing_next;
            blink_reg       <= blink_next;
            slot_reg        <= slot_next;
            rounds_reg      <= rounds_next;
            scan_d10_reg    <= scan_d10_next;
            scan_d100_reg   <= scan_d100_next;
            out_valid_reg   <= out_valid_next;
            skid_valid_reg  <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid     = out_valid_reg;
    assign strobe_fire   = out_reg.strobe_fire;
    assign adc_start     = out_reg.adc_start;
    assign segments_load = out_reg.segments_load;
    assign segments      = out_reg.segments;
    assign digit_enable  = out_reg.digit_enable;
    assign is_armed      = out_reg.is_armed;
    assign is_firing     = out_reg.is_firing;

endmodule
